>>> hdl/dsxf_pkg.sv
package dsxf_pkg;

	// Default frame limit, in decoded bytes.
	localparam int unsigned MAX_FRAME_BYTES_DEF = 4096;

	// Decoded byte offset of the sequence number.
	localparam int unsigned SEQ_OFFSET = 4;

	// Shortest frame, in decoded bytes, that can be good.
	localparam int unsigned MIN_FRAME_BYTES = 5;

	// Largest reportable payload length.
	localparam int unsigned LEN_MAX = 4095;

	// Configuration register indexes.
	localparam logic [1:0] REG_START_MARKER  = 2'd0;
	localparam logic [1:0] REG_END_MARKER    = 2'd1;
	localparam logic [1:0] REG_ESCAPE_MARKER = 2'd2;
	localparam logic [1:0] REG_EXPECTED_SEQ  = 2'd3;

	// Configuration reset values.
	localparam logic [7:0] START_MARKER_RST  = 8'h02;
	localparam logic [7:0] END_MARKER_RST    = 8'h03;
	localparam logic [7:0] ESCAPE_MARKER_RST = 8'h10;
	localparam logic [7:0] EXPECTED_SEQ_RST  = 8'h00;

	// Result kinds.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// Frame status codes.
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_ERROR   = 2'd1;
	localparam logic [1:0] STATUS_NO_DATA = 2'd2;

	// One received byte transaction.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_end;
		logic       no_data;
	} in_item_t;

	// One result transaction.
	typedef struct packed {
		logic        result_kind;
		logic [7:0]  payload_byte;
		logic [1:0]  frame_status;
		logic [11:0] payload_length;
	} out_item_t;

	// Configuration register set.
	typedef struct packed {
		logic [7:0] start_marker;
		logic [7:0] end_marker;
		logic [7:0] escape_marker;
		logic [7:0] expected_sequence;
	} cfg_t;

	// Result of one decode step.
	typedef struct packed {
		logic      valid;
		out_item_t item;
	} step_res_t;

endpackage

>>> hdl/dsxf_core.sv
module dsxf_core import dsxf_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output step_res_t res
);

	localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int unsigned LEN_W = (CNT_W > 12) ? CNT_W : 12;

	// Frame state.
	logic             in_frame_q, esc_pend_q, held_valid_q, err_q;
	logic [7:0]       xor_q, held_byte_q;
	logic [CNT_W-1:0] cnt_q;

	logic             in_frame_d, esc_pend_d, held_valid_d, err_d;
	logic [7:0]       xor_d, held_byte_d;
	logic [CNT_W-1:0] cnt_d;

	logic             is_esc, is_start, is_end, bad;
	logic [CNT_W-1:0] len_full;
	logic [LEN_W-1:0] len_ext;
	logic [11:0]      len_out;

	assign is_esc   = item.rx_byte == cfg.escape_marker;
	assign is_start = item.rx_byte == cfg.start_marker;
	assign is_end   = item.rx_byte == cfg.end_marker;

	// Status length: decoded bytes less the checksum, clamped to the field.
	assign len_full = (cnt_q != '0) ? cnt_q - CNT_W'(1) : '0;
	assign len_ext  = LEN_W'(len_full);
	assign len_out  = (len_ext > LEN_W'(LEN_MAX)) ? 12'(LEN_MAX) : len_ext[11:0];

	assign bad = err_q || esc_pend_q || !is_end || (xor_q != 8'd0) ||
		(cnt_q < CNT_W'(MIN_FRAME_BYTES));

	// Next state and result for the byte at the input register.
	always_comb begin
		logic do_decode;
		logic do_clear;
		do_decode    = 1'b0;
		do_clear     = 1'b0;
		in_frame_d   = in_frame_q;
		esc_pend_d   = esc_pend_q;
		held_valid_d = held_valid_q;
		err_d        = err_q;
		xor_d        = xor_q;
		held_byte_d  = held_byte_q;
		cnt_d        = cnt_q;
		res          = '0;

		if (item.no_data) begin
			do_clear = 1'b1;
			res.valid = 1'b1;
			res.item.result_kind  = KIND_STATUS;
			res.item.frame_status = STATUS_NO_DATA;
		end else if (!in_frame_q) begin
			do_clear = 1'b1;
			if (item.frame_end) begin
				res.valid = 1'b1;
				res.item.result_kind  = KIND_STATUS;
				res.item.frame_status = STATUS_ERROR;
			end
		end else if (item.frame_end) begin
			do_clear = 1'b1;
			res.valid = 1'b1;
			res.item.result_kind    = KIND_STATUS;
			res.item.frame_status   = bad ? STATUS_ERROR : STATUS_OK;
			res.item.payload_length = len_out;
		end else if (esc_pend_q) begin
			esc_pend_d = 1'b0;
			if (is_start || is_end || is_esc) begin
				do_decode = 1'b1;
			end else begin
				err_d = 1'b1;
			end
		end else if (is_esc) begin
			esc_pend_d = 1'b1;
		end else if (is_start || is_end) begin
			err_d = 1'b1;
		end else begin
			do_decode = 1'b1;
		end

		// A decoded byte joins the checksum and pushes out the held byte.
		if (do_decode) begin
			xor_d = xor_q ^ item.rx_byte;
			if (cnt_q == CNT_W'(SEQ_OFFSET) && item.rx_byte != cfg.expected_sequence) begin
				err_d = 1'b1;
			end
			if (cnt_q >= CNT_W'(MAX_FRAME_BYTES)) begin
				err_d = 1'b1;
			end else begin
				cnt_d = cnt_q + CNT_W'(1);
			end
			if (held_valid_q) begin
				res.valid = 1'b1;
				res.item.result_kind  = KIND_PAYLOAD;
				res.item.payload_byte = held_byte_q;
			end
			held_byte_d  = item.rx_byte;
			held_valid_d = 1'b1;
		end

		// Frame boundary: drop everything; a non-final first byte opens a frame.
		if (do_clear) begin
			esc_pend_d   = 1'b0;
			held_valid_d = 1'b0;
			xor_d        = 8'd0;
			held_byte_d  = 8'd0;
			cnt_d        = '0;
			in_frame_d   = !item.no_data && !in_frame_q && !item.frame_end;
			err_d        = in_frame_d && !is_start;
		end
	end

	// State registers advance once per processed transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			esc_pend_q   <= 1'b0;
			held_valid_q <= 1'b0;
			err_q        <= 1'b0;
			xor_q        <= 8'd0;
			held_byte_q  <= 8'd0;
			cnt_q        <= '0;
		end else if (step) begin
			in_frame_q   <= in_frame_d;
			esc_pend_q   <= esc_pend_d;
			held_valid_q <= held_valid_d;
			err_q        <= err_d;
			xor_q        <= xor_d;
			held_byte_q  <= held_byte_d;
			cnt_q        <= cnt_d;
		end
	end

endmodule

>>> hdl/dle_stuffed_xor_frame_decoder.sv
// Deframes a byte-stuffed receive stream (start, end and escape markers) and checks its XOR
// sum, sequence number and minimum length. One byte transaction is taken per clock unless
// in_stall is raised. Each byte is registered in the input register when taken, and its
// result, if any, is loaded into the output register once that register can take it.
// Throughput is one byte per cycle while the output is not stalled; a result held under
// stall blocks the input once the input register is also occupied. Decoded payload bytes
// come out one byte late so that the checksum is never delivered; the final byte of a frame
// yields one status transaction with the payload length, a timeout one with no-data status.
// Configuration writes are taken every cycle and must only be issued while the block is idle.
module dle_stuffed_xor_frame_decoder import dsxf_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cfg_t      cfg_q;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t out_q;
	logic      out_valid_q;
	logic      adv;
	step_res_t res;

	// The held byte is processed when the output register can take a result.
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker      <= START_MARKER_RST;
			cfg_q.end_marker        <= END_MARKER_RST;
			cfg_q.escape_marker     <= ESCAPE_MARKER_RST;
			cfg_q.expected_sequence <= EXPECTED_SEQ_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_START_MARKER:  cfg_q.start_marker      <= cfg_data;
				REG_END_MARKER:    cfg_q.end_marker        <= cfg_data;
				REG_ESCAPE_MARKER: cfg_q.escape_marker     <= cfg_data;
				REG_EXPECTED_SEQ:  cfg_q.expected_sequence <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	dsxf_core #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (adv),
		.item  (item_s1),
		.cfg   (cfg_q),
		.res   (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			out_q <= res.item;
		end
	end

endmodule
